@@ rtl/hat_pkg.sv @@
// Shared types and constants for the handle allocator table.
package hat_pkg;

  localparam int MAX_SLOTS     = 256;
  localparam int INITIAL_SLOTS = 8;
  localparam int SLOT_W        = $clog2(MAX_SLOTS);
  localparam int SIZE_W        = SLOT_W + 1;
  localparam int INIT_SIZE     = (INITIAL_SLOTS < MAX_SLOTS) ? INITIAL_SLOTS : MAX_SLOTS;

  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;
  localparam int DATA_W   = 32;

  localparam logic [FUNC_W-1:0] FUNC_REGISTER   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_UNREGISTER = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP     = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [DATA_W-1:0] handle;
    logic [DATA_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    entry_t            wdata;
    logic [SLOT_W-1:0] raddr;
  } mem_req_t;

endpackage

@@ rtl/hat_mem.sv @@
// Slot storage: handle and value per slot, one write and one registered read port.
module hat_mem (
  input  logic              clk,
  input  hat_pkg::mem_req_t req,
  output hat_pkg::entry_t   rdata
);
  import hat_pkg::*;

  entry_t mem [MAX_SLOTS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

@@ rtl/hat_ctrl.sv @@
// Sequencer: slot scan, rehash on growth, unregister and lookup, used bits.
module hat_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [hat_pkg::FUNC_W-1:0]   in_func,
  input  logic [hat_pkg::DATA_W-1:0]   in_handle,
  input  logic [hat_pkg::DATA_W-1:0]   in_entry_value,
  output logic                         out_valid,
  output logic [hat_pkg::STATUS_W-1:0] out_status,
  output logic [hat_pkg::DATA_W-1:0]   out_handle_out,
  output logic [hat_pkg::DATA_W-1:0]   out_value_out,
  output hat_pkg::mem_req_t            mem_req,
  input  hat_pkg::entry_t              mem_rdata
);
  import hat_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_CHK  = 5'b00100,
    S_GRD  = 5'b01000,
    S_GWR  = 5'b10000
  } state_t;

  state_t               state_r;
  logic [FUNC_W-1:0]    func_r;
  logic [DATA_W-1:0]    handle_r;
  logic [DATA_W-1:0]    value_r;
  logic [DATA_W-1:0]    next_r;
  logic [SIZE_W-1:0]    size_r;
  logic [SLOT_W-1:0]    cnt_r;
  logic [MAX_SLOTS-1:0] used_r;

  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [DATA_W-1:0]    out_handle_r;
  logic [DATA_W-1:0]    out_value_r;

  logic [SLOT_W-1:0] mask;
  logic [DATA_W-1:0] cand;
  logic [SLOT_W-1:0] cand_pos;
  logic              cand_free;
  logic [SLOT_W-1:0] hpos;
  logic              hit;
  logic              move;
  logic [SLOT_W-1:0] hi_pos;
  logic              accept;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign mask      = SLOT_W'(size_r - SIZE_W'(1));
  assign cand      = next_r + DATA_W'(cnt_r);
  assign cand_pos  = cand[SLOT_W-1:0] & mask;
  assign cand_free = !used_r[cand_pos] && (cand != '0);
  assign hpos      = handle_r[SLOT_W-1:0] & mask;
  assign hit       = used_r[hpos] && (mem_rdata.handle == handle_r);
  assign hi_pos    = cnt_r | size_r[SLOT_W-1:0];
  assign move      = (mem_rdata.handle[SLOT_W-1:0] & size_r[SLOT_W-1:0]) != '0;

  always_comb begin
    mem_req       = '0;
    mem_req.raddr = cnt_r;
    case (state_r)
      S_IDLE: mem_req.raddr = in_handle[SLOT_W-1:0] & mask;
      S_SCAN: begin
        mem_req.we           = cand_free;
        mem_req.waddr        = cand_pos;
        mem_req.wdata.handle = cand;
        mem_req.wdata.value  = value_r;
      end
      S_GWR: begin
        mem_req.we    = move;
        mem_req.waddr = hi_pos;
        mem_req.wdata = mem_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      next_r      <= DATA_W'(1);
      size_r      <= SIZE_W'(INIT_SIZE);
      used_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            func_r   <= in_func;
            handle_r <= in_handle;
            value_r  <= in_entry_value;
            cnt_r    <= '0;
            case (in_func)
              FUNC_REGISTER:   state_r <= S_SCAN;
              FUNC_UNREGISTER: state_r <= S_CHK;
              FUNC_LOOKUP:     state_r <= S_CHK;
              default: begin
                out_valid_r  <= 1'b1;
                out_status_r <= ST_NOT_FOUND;
                out_handle_r <= in_handle;
                out_value_r  <= '0;
              end
            endcase
          end
        end
        S_CHK: begin
          out_valid_r  <= 1'b1;
          out_status_r <= hit ? ST_OK : ST_NOT_FOUND;
          out_handle_r <= handle_r;
          out_value_r  <= (hit && func_r == FUNC_LOOKUP) ? mem_rdata.value : '0;
          if (hit && func_r == FUNC_UNREGISTER) begin
            used_r[hpos] <= 1'b0;
          end
          state_r <= S_IDLE;
        end
        S_SCAN: begin
          if (cand_free) begin
            used_r[cand_pos] <= 1'b1;
            next_r           <= cand + DATA_W'(1);
            out_valid_r      <= 1'b1;
            out_status_r     <= ST_OK;
            out_handle_r     <= cand;
            out_value_r      <= '0;
            state_r          <= S_IDLE;
          end else if (cnt_r == mask) begin
            cnt_r <= '0;
            if (size_r == SIZE_W'(MAX_SLOTS)) begin
              out_valid_r  <= 1'b1;
              out_status_r <= ST_FULL;
              out_handle_r <= '0;
              out_value_r  <= '0;
              state_r      <= S_IDLE;
            end else begin
              state_r <= S_GRD;
            end
          end else begin
            cnt_r <= cnt_r + SLOT_W'(1);
          end
        end
        S_GRD: begin
          if (used_r[cnt_r]) begin
            state_r <= S_GWR;
          end else if (cnt_r == mask) begin
            cnt_r   <= '0;
            size_r  <= size_r << 1;
            state_r <= S_SCAN;
          end else begin
            cnt_r <= cnt_r + SLOT_W'(1);
          end
        end
        S_GWR: begin
          if (move) begin
            used_r[cnt_r]  <= 1'b0;
            used_r[hi_pos] <= 1'b1;
          end
          if (cnt_r == mask) begin
            cnt_r   <= '0;
            size_r  <= size_r << 1;
            state_r <= S_SCAN;
          end else begin
            cnt_r   <= cnt_r + SLOT_W'(1);
            state_r <= S_GRD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_handle_out = out_handle_r;
  assign out_value_out  = out_value_r;

endmodule

@@ rtl/handle_allocator_table.sv @@
// Handle allocator table: top level.
// Lookup and unregister: start enters the check state, which registers the result.
// Register scans for a free slot; a rehash steps through each old slot and moves used ones as needed.
// One command at a time; busy is high until the result strobe is issued.
// Results are strobed for one cycle and cannot be stalled.
// Synchronous reset clears the used bits, counter to 1 and size to initial.
module handle_allocator_table (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [hat_pkg::FUNC_W-1:0]   in_func,
  input  logic [hat_pkg::DATA_W-1:0]   in_handle,
  input  logic [hat_pkg::DATA_W-1:0]   in_entry_value,
  output logic                         out_valid,
  output logic [hat_pkg::STATUS_W-1:0] out_status,
  output logic [hat_pkg::DATA_W-1:0]   out_handle_out,
  output logic [hat_pkg::DATA_W-1:0]   out_value_out
);
  import hat_pkg::*;

  mem_req_t mem_req;
  entry_t   mem_rdata;

  hat_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_handle      (in_handle),
    .in_entry_value (in_entry_value),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_handle_out (out_handle_out),
    .out_value_out  (out_value_out),
    .mem_req        (mem_req),
    .mem_rdata      (mem_rdata)
  );

  hat_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

@@ tb/sv/handle_allocator_table_test.sv @@
// Self-checking testbench for the handle allocator table: directed and random commands.
`timescale 1ns / 1ps

module handle_allocator_table_test;
  import hat_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int DRAIN_CYCLES = 1000;

  class reply_scoreboard;
    typedef struct {
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   handle;
      logic [DATA_W-1:0]   value;
    } reply_t;

    bit [DATA_W-1:0] slot_key [MAX_SLOTS];
    bit              slot_taken [MAX_SLOTS];
    bit [DATA_W-1:0] slot_val [MAX_SLOTS];
    bit [DATA_W-1:0] next_id;
    int unsigned     size;
    reply_t          pending_replies [$];
    int unsigned     errors;

    function new();
      next_id = 1;
      size    = INIT_SIZE;
      errors  = 0;
    endfunction

    function void double_table();
      bit [DATA_W-1:0] nk [MAX_SLOTS];
      bit              nt [MAX_SLOTS];
      bit [DATA_W-1:0] nv [MAX_SLOTS];
      int unsigned     wide;
      int unsigned     p;
      wide = size * 2;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        nk[i] = '0;
        nt[i] = 1'b0;
        nv[i] = '0;
      end
      for (int i = 0; i < size; i++) begin
        if (slot_taken[i]) begin
          p = slot_key[i] & (wide - 1);
          nk[p] = slot_key[i];
          nv[p] = slot_val[i];
          nt[p] = 1'b1;
        end
      end
      slot_key   = nk;
      slot_taken = nt;
      slot_val   = nv;
      size       = wide;
    endfunction

    function reply_t predict(logic [FUNC_W-1:0] fn, logic [DATA_W-1:0] h,
                             logic [DATA_W-1:0] v);
      reply_t          r;
      bit [DATA_W-1:0] cand;
      int unsigned     p;
      bit              done;
      r.status = ST_NOT_FOUND;
      r.handle = h;
      r.value  = '0;
      p = h & (size - 1);
      case (fn)
        FUNC_REGISTER: begin
          done = 1'b0;
          while (!done) begin
            for (int i = 0; i < size && !done; i++) begin
              cand = next_id + i;
              p = cand & (size - 1);
              if (!slot_taken[p] && cand != 0) begin
                slot_taken[p] = 1'b1;
                slot_key[p]   = cand;
                slot_val[p]   = v;
                next_id       = cand + 1;
                r.status      = ST_OK;
                r.handle      = cand;
                done          = 1'b1;
              end
            end
            if (!done) begin
              if (size * 2 > MAX_SLOTS) begin
                r.status = ST_FULL;
                r.handle = '0;
                done     = 1'b1;
              end else begin
                double_table();
              end
            end
          end
        end
        FUNC_UNREGISTER: begin
          if (slot_taken[p] && slot_key[p] == h) begin
            slot_taken[p] = 1'b0;
            r.status      = ST_OK;
          end
        end
        FUNC_LOOKUP: begin
          if (slot_taken[p] && slot_key[p] == h) begin
            r.status = ST_OK;
            r.value  = slot_val[p];
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note(logic [FUNC_W-1:0] fn, logic [DATA_W-1:0] h, logic [DATA_W-1:0] v);
      pending_replies.push_back(predict(fn, h, v));
    endfunction

    function void check(logic [STATUS_W-1:0] st, logic [DATA_W-1:0] h,
                        logic [DATA_W-1:0] v);
      reply_t exp;
      if (pending_replies.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: status %0d handle %h value %h", st, h, v);
        return;
      end
      exp = pending_replies.pop_front();
      if (st !== exp.status || h !== exp.handle || v !== exp.value) begin
        errors++;
        if (errors <= 10)
          $display("bad word: status %0d/%0d handle %h/%h value %h/%h (exp/act)",
                   exp.status, st, exp.handle, h, exp.value, v);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [FUNC_W-1:0]   in_func;
  logic [DATA_W-1:0]   in_handle;
  logic [DATA_W-1:0]   in_entry_value;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [DATA_W-1:0]   out_handle_out;
  logic [DATA_W-1:0]   out_value_out;

  reply_scoreboard sb;
  int unsigned     idle_pct;
  int unsigned     cycle_count;

  handle_allocator_table dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_handle      (in_handle),
    .in_entry_value (in_entry_value),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_handle_out (out_handle_out),
    .out_value_out  (out_value_out)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic send(logic [FUNC_W-1:0] fn, logic [DATA_W-1:0] h, logic [DATA_W-1:0] v);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start          <= 1'b1;
    in_func        <= fn;
    in_handle      <= h;
    in_entry_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note(fn, h, v);
  endtask

  // mostly live or stale keys, some aliasing the same slot, some random
  function automatic logic [DATA_W-1:0] pick_handle();
    int unsigned     r;
    logic [DATA_W-1:0] k;
    r = $urandom_range(0, 99);
    k = sb.slot_key[$urandom_range(0, sb.size - 1)];
    if (r < 65) return k;
    if (r < 80) return k ^ (32'h1 << $urandom_range(8, 31));
    return $urandom();
  endfunction

  task automatic run_random(int unsigned n, int unsigned pct);
    int unsigned r;
    idle_pct = pct;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 50)      send(FUNC_REGISTER, $urandom(), $urandom());
      else if (r < 72) send(FUNC_UNREGISTER, pick_handle(), $urandom());
      else if (r < 95) send(FUNC_LOOKUP, pick_handle(), $urandom());
      else             send(FUNC_UNUSED, pick_handle(), $urandom());
    end
  endtask

  initial begin
    sb             = new();
    idle_pct       = 28;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_func        = FUNC_REGISTER;
    in_handle      = '0;
    in_entry_value = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send(FUNC_LOOKUP, 32'h0, 32'h0);
    send(FUNC_UNREGISTER, 32'hffffffff, 32'h0);
    send(FUNC_UNUSED, 32'hffffffff, 32'hffffffff);
    send(FUNC_REGISTER, 32'h0, 32'h0);
    send(FUNC_REGISTER, 32'hffffffff, 32'hffffffff);
    send(FUNC_LOOKUP, 32'h1, 32'h0);
    send(FUNC_LOOKUP, 32'h2, 32'h0);
    send(FUNC_LOOKUP, 32'h80000001, 32'h0);
    send(FUNC_UNREGISTER, 32'h80000002, 32'h0);
    send(FUNC_UNREGISTER, 32'h2, 32'h0);
    send(FUNC_UNREGISTER, 32'h2, 32'h0);
    send(FUNC_LOOKUP, 32'h2, 32'h0);
    // fill past the initial size to force a rehash
    for (int i = 0; i < 9; i++)
      send(FUNC_REGISTER, $urandom(), (i % 2) ? 32'haaaaaaaa : 32'h55555555);
    send(FUNC_LOOKUP, 32'h1, 32'h0);
    send(FUNC_LOOKUP, 32'h8, 32'h0);
    send(FUNC_UNUSED, 32'h0, 32'h0);
    send(FUNC_LOOKUP, sb.next_id - 1, 32'h0);

    run_random(360, 28);
    run_random(360, 46);
    run_random(360, 0);

    @(negedge clk);
    start <= 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check(out_status, out_handle_out, out_value_out);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
